>>> rtl/hwsm_pkg.sv
// Shared constants, register indexes and inter-module types for the wheel speed pulse meter.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package hwsm_pkg;

    // timestamp width in bits (range 33..64)
    localparam int TIME_BITS = 48;

    // microseconds per millisecond
    localparam int MS_DIV   = 1000;
    localparam int MS_REM_W = $clog2(MS_DIV);

    // divide by 1000 one 16-bit digit at a time: x = {rem, digit} < 1000 * 2^16,
    // digit quotient = (x * ceil(2^36 / 1000)) >> 36, exact over that range
    localparam int MS_DIG_W    = 16;
    localparam int MS_DIGITS   = (TIME_BITS + MS_DIG_W - 1) / MS_DIG_W;
    localparam int MS_PAD_W    = MS_DIGITS * MS_DIG_W;
    localparam int TCNT_W      = $clog2(MS_DIGITS);
    localparam int MS_X_W      = MS_REM_W + MS_DIG_W;
    localparam int MS_RECIP_SH = 36;
    localparam int MS_RECIP_W  = 27;
    localparam int MS_PROD_W   = MS_X_W + MS_RECIP_W;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = MS_RECIP_W'(68719477);

    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 15;
    localparam int MS_CFG_W = 16;
    localparam int MS_W     = 32;
    localparam int INT_W    = 32;
    localparam int NUM_W    = 40;
    localparam int DCNT_W   = $clog2(NUM_W);

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = NUM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_THRESHOLD  = 4'd0,
        REG_DEBOUNCE_MS      = 4'd1,
        REG_SPEED_TIMEOUT_MS = 4'd2,
        REG_SPEED_NUMERATOR  = 4'd3
    } reg_index_t;

    localparam logic [THRESH_W-1:0] THRESH_RESET   = THRESH_W'(500);
    localparam logic [MS_CFG_W-1:0] DEBOUNCE_RESET = MS_CFG_W'(125);
    localparam logic [MS_CFG_W-1:0] TIMEOUT_RESET  = MS_CFG_W'(3000);
    localparam logic [NUM_W-1:0]    NUM_RESET      = NUM_W'(1202826240);

    // depth of the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // settings the front needs
    typedef struct packed {
        logic [THRESH_W-1:0] field_threshold;
        logic [MS_CFG_W-1:0] min_gap_ms;
        logic [MS_CFG_W-1:0] speed_timeout_ms;
    } front_cfg_t;

    // one classified sample, front to back
    typedef struct packed {
        logic             pulse;
        logic             first;
        logic [INT_W-1:0] interval;
        logic             do_div;
    } job_t;

endpackage

`default_nettype wire

>>> rtl/hwsm_queue.sv
// Short FIFO of classified jobs between the front and back sections.
// Uses hwsm_pkg for the job type and depth.
`default_nettype none

module hwsm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  hwsm_pkg::job_t     wr_data,
    output logic               full,
    input  wire logic          pop,
    output hwsm_pkg::job_t     rd_data,
    output logic               empty
);

    hwsm_pkg::job_t                  mem [hwsm_pkg::QDEPTH];
    logic [hwsm_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hwsm_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hwsm_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            do_wr, do_rd;

    assign full    = (cnt_reg == hwsm_pkg::QCNT_W'(hwsm_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == hwsm_pkg::QPTR_W'(hwsm_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == hwsm_pkg::QPTR_W'(hwsm_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hwsm_front.sv
// Front section: accepts samples, derives millisecond time with a digit-wise reciprocal
// multiply by 1/1000, qualifies pulses and keeps the pulse/interval state. Uses hwsm_pkg.
`default_nettype none

module hwsm_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [hwsm_pkg::SAMPLE_W-1:0] field_sample,
    input  wire logic [hwsm_pkg::TIME_BITS-1:0]     time_us,
    input  hwsm_pkg::front_cfg_t                    cfg,
    output logic                                    job_push,
    output hwsm_pkg::job_t                          job,
    input  wire logic                               job_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_SUB  = 4'b0100,
        F_DONE = 4'b1000
    } front_state_t;

    localparam int TB = hwsm_pkg::TIME_BITS;
    localparam int PW = hwsm_pkg::MS_PAD_W;
    localparam int DW = hwsm_pkg::MS_DIG_W;

    front_state_t                         state_reg, state_next;
    logic [hwsm_pkg::TCNT_W-1:0]          cnt_reg, cnt_next;
    logic [PW-1:0]                        quo_reg, quo_next;
    logic [hwsm_pkg::MS_REM_W-1:0]        rem_reg, rem_next;
    logic [DW-1:0]                        q_reg, q_next;
    logic [TB-1:0]                        time_reg;
    logic signed [hwsm_pkg::SAMPLE_W-1:0] sample_reg;

    logic                                 was_above_reg, have_cross_reg, have_int_reg;
    logic [TB-1:0]                        prev_cross_reg;
    logic [hwsm_pkg::MS_W-1:0]            last_ms_reg;
    logic [hwsm_pkg::INT_W-1:0]           stored_int_reg;

    logic [hwsm_pkg::MS_X_W-1:0]          x_cur, x_back;
    logic [hwsm_pkg::MS_PROD_W-1:0]       prod;
    logic [hwsm_pkg::MS_W-1:0]            now_ms, since, age, last_ms_new;
    logic [hwsm_pkg::SAMPLE_W-1:0]        mag;
    logic                                 above, pulse, first, have_int_new;
    logic [TB-1:0]                        delta;
    logic [hwsm_pkg::INT_W-1:0]           delta_sat, int_new;
    logic                                 commit;

    assign full = (state_reg != F_IDLE);

    // long division by 1000 in 16-bit digits: multiply step (F_MUL), then remainder step (F_SUB)
    assign x_cur  = {rem_reg, quo_reg[PW-1:PW-DW]};
    assign prod   = hwsm_pkg::MS_PROD_W'(x_cur) * hwsm_pkg::MS_PROD_W'(hwsm_pkg::MS_RECIP);
    assign q_next = prod[hwsm_pkg::MS_RECIP_SH+DW-1:hwsm_pkg::MS_RECIP_SH];
    assign x_back = x_cur - (hwsm_pkg::MS_X_W'(q_reg) * hwsm_pkg::MS_X_W'(hwsm_pkg::MS_DIV));

    // classification, evaluated once the quotient is complete
    assign now_ms = quo_reg[hwsm_pkg::MS_W-1:0];
    assign mag    = sample_reg[hwsm_pkg::SAMPLE_W-1] ?
                    hwsm_pkg::SAMPLE_W'(-sample_reg) : hwsm_pkg::SAMPLE_W'(sample_reg);
    assign above  = (mag > hwsm_pkg::SAMPLE_W'(cfg.field_threshold));
    assign since  = now_ms - last_ms_reg;
    assign pulse  = above && !was_above_reg &&
                    (!have_cross_reg || (since >= hwsm_pkg::MS_W'(cfg.min_gap_ms)));
    assign first  = pulse && !have_cross_reg;

    assign delta     = time_reg - prev_cross_reg;
    assign delta_sat = (|delta[TB-1:hwsm_pkg::INT_W]) ? '1 : delta[hwsm_pkg::INT_W-1:0];

    assign int_new      = (pulse && have_cross_reg) ? delta_sat : stored_int_reg;
    assign have_int_new = have_int_reg || (pulse && have_cross_reg);
    assign last_ms_new  = pulse ? now_ms : last_ms_reg;
    assign age          = now_ms - last_ms_new;

    assign commit   = (state_reg == F_DONE) && !job_full;
    assign job_push = commit;

    always_comb
    begin
        job.pulse    = pulse;
        job.first    = first;
        job.interval = int_new;
        // have_cross is set whenever an interval exists
        job.do_div   = have_int_new && (int_new != '0) &&
                       (age <= hwsm_pkg::MS_W'(cfg.speed_timeout_ms));
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    quo_next   = PW'(time_us);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_SUB;
            end
            F_SUB:
            begin
                quo_next = {quo_reg[PW-DW-1:0], q_reg};
                rem_next = x_back[hwsm_pkg::MS_REM_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hwsm_pkg::TCNT_W'(hwsm_pkg::MS_DIGITS - 1))
                begin
                    state_next = F_DONE;
                end
                else
                begin
                    state_next = F_MUL;
                end
            end
            F_DONE:
            begin
                if (!job_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            cnt_reg        <= '0;
            was_above_reg  <= 1'b0;
            have_cross_reg <= 1'b0;
            have_int_reg   <= 1'b0;
            prev_cross_reg <= '0;
            last_ms_reg    <= '0;
            stored_int_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (commit)
            begin
                was_above_reg  <= above;
                have_cross_reg <= have_cross_reg || pulse;
                have_int_reg   <= have_int_new;
                stored_int_reg <= int_new;
                last_ms_reg    <= last_ms_new;
                if (pulse)
                begin
                    prev_cross_reg <= time_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if ((state_reg == F_IDLE) && push)
        begin
            time_reg   <= time_us;
            sample_reg <= field_sample;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hwsm_back.sv
// Back section: divides the speed numerator by the interval one bit per cycle
// and holds the finished word in the output register. Uses hwsm_pkg.
`default_nettype none

module hwsm_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [hwsm_pkg::NUM_W-1:0]   numerator,
    input  wire logic                         job_empty,
    input  hwsm_pkg::job_t                    job,
    output logic                              job_pop,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              pulse_seen,
    output logic                              first_pulse,
    output logic [hwsm_pkg::INT_W-1:0]        interval_us,
    output logic [hwsm_pkg::NUM_W-1:0]        speed_q8
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    localparam int NW = hwsm_pkg::NUM_W;
    localparam int IW = hwsm_pkg::INT_W;

    back_state_t                  state_reg, state_next;
    logic [hwsm_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]                quo_reg, quo_next;
    logic [IW-1:0]                rem_reg, rem_next;
    hwsm_pkg::job_t               job_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [IW:0]                  trial;
    logic                         trial_ge;
    logic                         load_out;

    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign trial_ge = (trial >= {1'b0, job_reg.interval});

    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    quo_next   = job.do_div ? numerator : '0;
                    state_next = job.do_div ? B_DIV : B_DONE;
                end
            end
            B_DIV:
            begin
                quo_next = {quo_reg[NW-2:0], trial_ge};
                rem_next = trial_ge ? IW'(trial - {1'b0, job_reg.interval}) : trial[IW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hwsm_pkg::DCNT_W'(NW - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (load_out)
        begin
            pulse_seen  <= job_reg.pulse;
            first_pulse <= job_reg.first;
            interval_us <= job_reg.interval;
            speed_q8    <= quo_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hall_wheel_speed_pulse_meter_top.sv
// Top level of the wheel speed pulse meter: configuration registers, front, queue, back.
// Depends on hwsm_pkg, hwsm_front, hwsm_queue and hwsm_back.
//
// Usage:
//   Input side is a queue: a sample word (field_sample, time_us) is taken on a
//   clock edge with push high and full low. Result side is a queue: while empty
//   is low the oldest result word is on pulse_seen/first_pulse/interval_us/
//   speed_q8 and is taken on an edge with pop high.
//   Config port: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 threshold, 1 debounce ms, 2 timeout ms, 3 numerator;
//   other indexes are ignored. Write only while the block is idle.
//   Flow: the front takes a new sample only once the last one has left it; its
//   divide by 1000 runs a multiply step and a remainder step per 16-bit digit,
//   then waits for room in the queue. The back takes a new word only after the
//   last is done, and runs its NUM_W-bit speed divide only for a word needing it.
//   A two-word queue sits between front and back, and the back holds one
//   finished word in its output register, so a stalled receiver does not stop
//   sample intake until those fill; then full stays high.
//   Reset: configuration returns to its defaults, pulse state is cleared and
//   both queues are empty; no clearing pass is needed.
`default_nettype none

module hall_wheel_speed_pulse_meter_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [hwsm_pkg::SAMPLE_W-1:0] field_sample,
    input  wire logic [hwsm_pkg::TIME_BITS-1:0]       time_us,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic                                      pulse_seen,
    output logic                                      first_pulse,
    output logic [hwsm_pkg::INT_W-1:0]                interval_us,
    output logic [hwsm_pkg::NUM_W-1:0]                speed_q8,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hwsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hwsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [hwsm_pkg::THRESH_W-1:0] thresh_reg;
    logic [hwsm_pkg::MS_CFG_W-1:0] debounce_reg;
    logic [hwsm_pkg::MS_CFG_W-1:0] timeout_reg;
    logic [hwsm_pkg::NUM_W-1:0]    num_reg;
    hwsm_pkg::front_cfg_t          front_cfg;

    logic                          fq_push, fq_full, fq_pop, fq_empty;
    hwsm_pkg::job_t                fq_wr, fq_rd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= hwsm_pkg::THRESH_RESET;
            debounce_reg <= hwsm_pkg::DEBOUNCE_RESET;
            timeout_reg  <= hwsm_pkg::TIMEOUT_RESET;
            num_reg      <= hwsm_pkg::NUM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hwsm_pkg::REG_FIELD_THRESHOLD:
                    thresh_reg <= cfg_data[hwsm_pkg::THRESH_W-1:0];
                hwsm_pkg::REG_DEBOUNCE_MS:
                    debounce_reg <= cfg_data[hwsm_pkg::MS_CFG_W-1:0];
                hwsm_pkg::REG_SPEED_TIMEOUT_MS:
                    timeout_reg <= cfg_data[hwsm_pkg::MS_CFG_W-1:0];
                hwsm_pkg::REG_SPEED_NUMERATOR:
                    num_reg <= cfg_data[hwsm_pkg::NUM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        front_cfg.field_threshold  = thresh_reg;
        front_cfg.min_gap_ms       = debounce_reg;
        front_cfg.speed_timeout_ms = timeout_reg;
    end

    hwsm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .field_sample (field_sample),
        .time_us      (time_us),
        .cfg          (front_cfg),
        .job_push     (fq_push),
        .job          (fq_wr),
        .job_full     (fq_full)
    );

    hwsm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data (fq_wr),
        .full    (fq_full),
        .pop     (fq_pop),
        .rd_data (fq_rd),
        .empty   (fq_empty)
    );

    hwsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .numerator   (num_reg),
        .job_empty   (fq_empty),
        .job         (fq_rd),
        .job_pop     (fq_pop),
        .empty       (empty),
        .pop         (pop),
        .pulse_seen  (pulse_seen),
        .first_pulse (first_pulse),
        .interval_us (interval_us),
        .speed_q8    (speed_q8)
    );

    // first pulse flag only rides on an accepted pulse
    a_first_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && first_pulse |-> pulse_seen)
        else $error("first_pulse without pulse_seen");

    // a nonzero speed needs a nonzero recorded interval
    a_speed_needs_interval: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (speed_q8 != '0) |-> (interval_us != '0))
        else $error("speed reported with zero interval");

    // the front is busy right after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("front ready again right after accepting a word");

endmodule

`default_nettype wire

>>> tb/hwsm_speed_checker.sv
// Scoreboard for the wheel speed pulse meter: follows register writes, predicts one result word
// per accepted sample and compares it with each word popped from the block.
// Depends on hwsm_pkg only.

module hwsm_speed_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic signed [hwsm_pkg::SAMPLE_W-1:0] field_sample,
    input  logic [hwsm_pkg::TIME_BITS-1:0]       time_us,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic                                 pulse_seen,
    input  logic                                 first_pulse,
    input  logic [hwsm_pkg::INT_W-1:0]           interval_us,
    input  logic [hwsm_pkg::NUM_W-1:0]           speed_q8,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [hwsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hwsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   mismatch_count,
    output int                                   words_waiting,
    output int                                   words_checked,
    output int                                   pulses_predicted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         pulse;
        logic                         first;
        logic [hwsm_pkg::INT_W-1:0]   interval;
        logic [hwsm_pkg::NUM_W-1:0]   speed;
    } meter_word_t;

    meter_word_t expected_words[$];

    // register copies
    logic [hwsm_pkg::THRESH_W-1:0]  thresh;
    logic [hwsm_pkg::MS_CFG_W-1:0]  debounce;
    logic [hwsm_pkg::MS_CFG_W-1:0]  timeout;
    logic [hwsm_pkg::NUM_W-1:0]     speed_num;

    // pulse tracking state
    logic                           was_above;
    logic [hwsm_pkg::TIME_BITS-1:0] prev_cross;
    logic                           have_cross;
    logic [hwsm_pkg::MS_W-1:0]      last_ms;
    logic                           have_interval;
    logic [hwsm_pkg::INT_W-1:0]     stored_interval;

    int fails   = 0;
    int checked = 0;
    int pulses  = 0;

    task automatic check_field(input string name, input logic [63:0] want_v, got_v);
        if (want_v !== got_v) begin
            $display("time %0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            fails++;
        end
    endtask

    task automatic step_meter(input logic signed [hwsm_pkg::SAMPLE_W-1:0] sample,
                              input logic [hwsm_pkg::TIME_BITS-1:0] t,
                              output meter_word_t w);
        logic [hwsm_pkg::SAMPLE_W:0]    mag;
        logic [hwsm_pkg::TIME_BITS-1:0] ms_full;
        logic [hwsm_pkg::TIME_BITS-1:0] span;
        logic [hwsm_pkg::MS_W-1:0]      now_ms;
        logic [hwsm_pkg::MS_W-1:0]      since;
        logic                           above;
        // sign-extend then negate so that -32768 gives 32768
        mag = sample[hwsm_pkg::SAMPLE_W-1] ? (17'd0 - {sample[hwsm_pkg::SAMPLE_W-1], sample})
                                           : {1'b0, sample};
        ms_full = t / hwsm_pkg::MS_DIV;
        now_ms  = ms_full[hwsm_pkg::MS_W-1:0];
        above   = mag > {2'b00, thresh};
        w = '0;
        if (above && !was_above) begin
            since = now_ms - last_ms;
            if (!have_cross || since >= 32'(debounce)) begin
                w.pulse = 1'b1;
                if (!have_cross) begin
                    w.first = 1'b1;
                end else begin
                    span = t - prev_cross;
                    stored_interval = (|span[hwsm_pkg::TIME_BITS-1:hwsm_pkg::INT_W]) ?
                                      '1 : span[hwsm_pkg::INT_W-1:0];
                    have_interval = 1'b1;
                end
                prev_cross = t;
                last_ms    = now_ms;
                have_cross = 1'b1;
            end
        end
        was_above  = above;
        w.interval = stored_interval;
        if (have_cross && have_interval && stored_interval != '0 &&
            (now_ms - last_ms) <= 32'(timeout))
            w.speed = speed_num / hwsm_pkg::NUM_W'(stored_interval);
    endtask

    always @(posedge clk) begin : watch
        meter_word_t want;
        meter_word_t got;
        meter_word_t fresh;
        if (!rst_n) begin
            thresh          = hwsm_pkg::THRESH_RESET;
            debounce        = hwsm_pkg::DEBOUNCE_RESET;
            timeout         = hwsm_pkg::TIMEOUT_RESET;
            speed_num       = hwsm_pkg::NUM_RESET;
            was_above       = 1'b0;
            prev_cross      = '0;
            have_cross      = 1'b0;
            last_ms         = '0;
            have_interval   = 1'b0;
            stored_interval = '0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    hwsm_pkg::REG_FIELD_THRESHOLD:  thresh    = cfg_data[hwsm_pkg::THRESH_W-1:0];
                    hwsm_pkg::REG_DEBOUNCE_MS:      debounce  = cfg_data[hwsm_pkg::MS_CFG_W-1:0];
                    hwsm_pkg::REG_SPEED_TIMEOUT_MS: timeout   = cfg_data[hwsm_pkg::MS_CFG_W-1:0];
                    hwsm_pkg::REG_SPEED_NUMERATOR:  speed_num = cfg_data[hwsm_pkg::NUM_W-1:0];
                    default: ;
                endcase
            end
            // the popped word always belongs to an older sample, so compare first
            if (pop && !empty) begin
                got = {pulse_seen, first_pulse, interval_us, speed_q8};
                if (expected_words.size() == 0) begin
                    $display("time %0t: unexpected result word, expected none, actual %h",
                             $time, got);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("pulse_seen", 64'(want.pulse), 64'(got.pulse));
                    check_field("first_pulse", 64'(want.first), 64'(got.first));
                    check_field("interval_us", 64'(want.interval), 64'(got.interval));
                    check_field("speed_q8", 64'(want.speed), 64'(got.speed));
                    checked++;
                end
            end
            if (push && !full) begin
                step_meter(field_sample, time_us, fresh);
                if (fresh.pulse)
                    pulses++;
                expected_words.push_back(fresh);
            end
        end
        mismatch_count   <= fails;
        words_waiting    <= expected_words.size();
        words_checked    <= checked;
        pulses_predicted <= pulses;
    end

endmodule

>>> tb/tb_hall_wheel_speed_pulse_meter_top.sv
// Stimulus and verdict for the wheel speed pulse meter: directed corner samples, then
// random pulse trains under several register settings. Depends on hwsm_pkg, hwsm_speed_checker and the top module.

module tb_hall_wheel_speed_pulse_meter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int LONG_HOLD   = 400;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 push;
    logic                                 full;
    logic signed [hwsm_pkg::SAMPLE_W-1:0] field_sample;
    logic [hwsm_pkg::TIME_BITS-1:0]       time_us;
    logic                                 empty;
    logic                                 pop;
    logic                                 pulse_seen;
    logic                                 first_pulse;
    logic [hwsm_pkg::INT_W-1:0]           interval_us;
    logic [hwsm_pkg::NUM_W-1:0]           speed_q8;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [hwsm_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [hwsm_pkg::CFG_DATA_W-1:0]      cfg_data;

    int mismatch_count;
    int words_waiting;
    int words_checked;
    int pulses_predicted;

    // stimulus-side bookkeeping
    logic [hwsm_pkg::THRESH_W-1:0]  thr_now;
    logic [hwsm_pkg::TIME_BITS-1:0] clock_us;
    logic                           last_above;
    logic                           sender_calm = 1'b0;
    int                             burst_left  = 0;
    int                             items_sent  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hall_wheel_speed_pulse_meter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .field_sample (field_sample),
        .time_us      (time_us),
        .empty        (empty),
        .pop          (pop),
        .pulse_seen   (pulse_seen),
        .first_pulse  (first_pulse),
        .interval_us  (interval_us),
        .speed_q8     (speed_q8),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    hwsm_speed_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .field_sample     (field_sample),
        .time_us          (time_us),
        .empty            (empty),
        .pop              (pop),
        .pulse_seen       (pulse_seen),
        .first_pulse      (first_pulse),
        .interval_us      (interval_us),
        .speed_q8         (speed_q8),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .words_waiting    (words_waiting),
        .words_checked    (words_checked),
        .pulses_predicted (pulses_predicted)
    );

    task automatic send_sample(input logic [hwsm_pkg::SAMPLE_W-1:0] s,
                               input logic [hwsm_pkg::TIME_BITS-1:0] t);
        int gap;
        if (burst_left == 0) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            burst_left  = 40;
        end
        burst_left--;
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        field_sample <= s;
        time_us      <= t;
        push         <= 1'b1;
        do @(posedge clk); while (full !== 1'b0);
        items_sent++;
    endtask

    // stop offering words and wait for every predicted word to come back
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge clk); while (words_waiting != 0);
    endtask

    // all four registers plus one write to an unused index, valid held across the burst
    task automatic write_settings(input logic [hwsm_pkg::CFG_DATA_W-1:0] thr_d, deb_d, to_d,
                                  num_d);
        logic [hwsm_pkg::CFG_IDX_W-1:0]  idx[5];
        logic [hwsm_pkg::CFG_DATA_W-1:0] val[5];
        idx[0] = hwsm_pkg::REG_FIELD_THRESHOLD;
        idx[1] = hwsm_pkg::CFG_IDX_W'($urandom_range(int'(hwsm_pkg::REG_SPEED_NUMERATOR) + 1,
                                                     2 ** hwsm_pkg::CFG_IDX_W - 1));
        idx[2] = hwsm_pkg::REG_DEBOUNCE_MS;
        idx[3] = hwsm_pkg::REG_SPEED_TIMEOUT_MS;
        idx[4] = hwsm_pkg::REG_SPEED_NUMERATOR;
        val[0] = thr_d;
        val[1] = hwsm_pkg::CFG_DATA_W'({$urandom, $urandom});
        val[2] = deb_d;
        val[3] = to_d;
        val[4] = num_d;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
        thr_now = thr_d[hwsm_pkg::THRESH_W-1:0];
    endtask

    // fills the bits above a register's width with junk half the time
    function automatic logic [hwsm_pkg::CFG_DATA_W-1:0] with_junk(input int value, input int width);
        logic [hwsm_pkg::CFG_DATA_W-1:0] junk;
        junk = hwsm_pkg::CFG_DATA_W'({$urandom, $urandom});
        if ($urandom_range(0, 1))
            return (junk << width) | hwsm_pkg::CFG_DATA_W'(value);
        return hwsm_pkg::CFG_DATA_W'(value);
    endfunction

    function automatic logic [hwsm_pkg::SAMPLE_W-1:0] shaped_sample(input logic above);
        int mag;
        if (above)
            mag = $urandom_range(int'(thr_now) + 1, 32768);
        else
            mag = $urandom_range(0, int'(thr_now));
        if (mag == 32768)
            return 16'h8000;
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    endfunction

    // mostly alternating above/below trains on a ms time scale, the rest noise and time jumps
    task automatic run_phase(input int count);
        logic [hwsm_pkg::SAMPLE_W-1:0]  s;
        logic [hwsm_pkg::TIME_BITS-1:0] step;
        logic                           want_above;
        repeat (count) begin
            if ($urandom_range(0, 99) < 80) begin
                want_above = ($urandom_range(0, 4) == 0) ? last_above : !last_above;
                case ($urandom_range(0, 3))
                    0:       step = hwsm_pkg::TIME_BITS'($urandom_range(0, 3000));
                    1, 2:    step = hwsm_pkg::TIME_BITS'($urandom_range(1, 400) * 1000 +
                                                         $urandom_range(0, 999));
                    default: step = hwsm_pkg::TIME_BITS'($urandom_range(500, 6000) * 1000);
                endcase
                clock_us  += step;
                s          = shaped_sample(want_above);
                last_above = want_above;
            end else begin
                s = hwsm_pkg::SAMPLE_W'($urandom);
                case ($urandom_range(0, 3))
                    0:       clock_us = hwsm_pkg::TIME_BITS'({$urandom, $urandom});
                    1:       clock_us = '1 - hwsm_pkg::TIME_BITS'($urandom_range(0, 400000));
                    2:       clock_us -= hwsm_pkg::TIME_BITS'($urandom_range(0, 100000));
                    default: clock_us += {16'($urandom_range(1, 3)), 32'($urandom)};
                endcase
            end
            send_sample(s, clock_us);
        end
    endtask

    initial begin : result_sink
        int   gap;
        int   taken;
        int   calm_left;
        logic calm;
        pop      <= 1'b0;
        taken     = 0;
        calm_left = 0;
        calm      = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = 40;
            end
            calm_left--;
            // long stall so the block backs up and raises full
            if (taken == 200 || taken == 900)
                gap = LONG_HOLD;
            else
                gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            taken++;
        end
    end

    initial begin : stimulus
        logic [hwsm_pkg::CFG_DATA_W-1:0] thr_d;
        logic [hwsm_pkg::CFG_DATA_W-1:0] deb_d;
        logic [hwsm_pkg::CFG_DATA_W-1:0] to_d;
        logic [hwsm_pkg::CFG_DATA_W-1:0] num_d;
        rst_n        <= 1'b0;
        push         <= 1'b0;
        field_sample <= '0;
        time_us      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        thr_now       = hwsm_pkg::THRESH_RESET;
        last_above    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first pulse, debounce reject, stale, saturation, timestamp wrap
        send_sample(16'sd0, 48'd0);
        send_sample(16'sd32767, 48'd1000);
        send_sample(16'h8000, 48'd2000);
        send_sample(16'sd500, 48'd3000);
        send_sample(-16'sd501, 48'd50000);
        send_sample(-16'sd1, 48'd60000);
        send_sample(16'sd501, 48'd201000);
        send_sample(16'sd0, 48'd3201000);
        send_sample(16'sd0, 48'd3202000);
        send_sample(16'sd12345, 48'd4295168303);
        send_sample(16'sd0, 48'hFFFF_FFFF_FFF0);
        send_sample(-16'sd20000, 48'hFFFF_FFFF_FFFF);
        send_sample(16'sd0, 48'd500);
        send_sample(16'sd20000, 48'd200500);
        drain_results();

        // no debounce: two pulses at one timestamp give a zero interval
        write_settings(hwsm_pkg::CFG_DATA_W'(hwsm_pkg::THRESH_RESET), '0,
                       hwsm_pkg::CFG_DATA_W'(hwsm_pkg::TIMEOUT_RESET), hwsm_pkg::NUM_RESET);
        send_sample(16'sd0, 48'd300000);
        send_sample(16'sd700, 48'd300000);
        send_sample(16'sd0, 48'd300000);
        send_sample(-16'sd700, 48'd300000);
        send_sample(16'sd0, 48'd301000);
        drain_results();

        clock_us = 48'd301000;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin
                    thr_d = '0;
                    deb_d = '0;
                    to_d  = '0;
                    num_d = '0;
                end
                1: begin
                    thr_d = '1;
                    deb_d = '1;
                    to_d  = '1;
                    num_d = '1;
                end
                default: begin
                    thr_d = with_junk(($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
                                                                 : $urandom_range(0, 4000),
                                      hwsm_pkg::THRESH_W);
                    deb_d = with_junk($urandom_range(0, 300), hwsm_pkg::MS_CFG_W);
                    to_d  = with_junk($urandom_range(0, 4000), hwsm_pkg::MS_CFG_W);
                    num_d = hwsm_pkg::CFG_DATA_W'({$urandom, $urandom});
                end
            endcase
            write_settings(thr_d, deb_d, to_d, num_d);
            run_phase(PHASE_ITEMS);
            drain_results();
        end

        repeat (hwsm_pkg::TIME_BITS + hwsm_pkg::NUM_W + 16) @(posedge clk);
        $display("run covered %0d samples under %0d register settings, %0d result words checked",
                 items_sent, PHASES + 2, words_checked);
        $display("%0d debounced pulses predicted, %0d mismatches", pulses_predicted,
                 mismatch_count);
        if (mismatch_count == 0 && words_waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hwsm_pkg.sv
rtl/hwsm_queue.sv
rtl/hwsm_front.sv
rtl/hwsm_back.sv
rtl/hall_wheel_speed_pulse_meter_top.sv
tb/hwsm_speed_checker.sv
tb/tb_hall_wheel_speed_pulse_meter_top.sv
